### rtl/hsv2rgb_pkg.sv
// Shared types, constants and rounding helper for the HSV to RGB converter.
package hsv2rgb_pkg;

  // Pixel component width and derived scale values.
  localparam int ColorBits = 8;
  localparam int ProdBits  = 2 * ColorBits;
  localparam logic [ColorBits-1:0] MaxV  = '1;
  localparam logic [ColorBits-1:0] HalfV = MaxV >> 1;

  // Hue format: one 60-degree sector spans 3840 = 15 * 256 units.
  localparam int HueBits   = 15;
  localparam int SpanShift = 8;
  localparam int HueHiBits = HueBits - SpanShift;
  localparam int RemHiBits = 4;
  localparam int RemBits   = RemHiBits + SpanShift;
  localparam int SecBits   = 4;

  // hue[14:8] / 15 as (x * 137) >> 11, exact for every 7-bit x.
  localparam int SecMulBits = 15;
  localparam int HueSecMul  = 137;
  localparam int HueSecShift = 11;

  // Product rem * MaxV and its division by 3840.
  localparam int RemmBits   = RemBits + ColorBits;
  localparam int DivInBits  = RemmBits - SpanShift;
  localparam int RecipShift = ColorBits + 8;
  localparam int RecipBits  = RecipShift - 3;
  localparam logic [RecipBits-1:0] Recip15 = RecipBits'(((1 << RecipShift) + 14) / 15);
  localparam int FMulBits   = DivInBits + RecipBits;

  // Sector codes; anything above the blue-red sector uses the last sector.
  localparam logic [SecBits-1:0] SecRedGrn = 4'd0;
  localparam logic [SecBits-1:0] SecGrnRed = 4'd1;
  localparam logic [SecBits-1:0] SecGrnBlu = 4'd2;
  localparam logic [SecBits-1:0] SecBluGrn = 4'd3;
  localparam logic [SecBits-1:0] SecBluRed = 4'd4;

  typedef struct packed {
    logic [HueBits-1:0]   hue;
    logic [ColorBits-1:0] saturation;
    logic [ColorBits-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [ColorBits-1:0] red;
    logic [ColorBits-1:0] green;
    logic [ColorBits-1:0] blue;
  } rgb_t;

  // Between fraction and product sections.
  typedef struct packed {
    logic [SecBits-1:0]   sector;
    logic [ColorBits-1:0] sat;
    logic [ColorBits-1:0] bri;
    logic [ColorBits-1:0] f;
    logic [ProdBits-1:0]  pv;
  } frac_t;

  // Between product section and output select.
  typedef struct packed {
    logic [SecBits-1:0]   sector;
    logic [ColorBits-1:0] bri;
    logic [ColorBits-1:0] p;
    logic [ProdBits-1:0]  qv;
    logic [ProdBits-1:0]  tv;
  } prod_t;

  // Round-to-nearest division by MaxV, valid for x up to MaxV * MaxV.
  function automatic logic [ColorBits-1:0] rnd_div(input logic [ProdBits-1:0] x);
    logic [ProdBits:0] y;
    logic [ProdBits:0] z;
    y = {1'b0, x} + (ProdBits + 1)'(HalfV);
    z = y + (y >> ColorBits) + (ProdBits + 1)'(1);
    return z[ColorBits +: ColorBits];
  endfunction

endpackage

### rtl/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB pixel converter.
//
// Usage:
//   Input channel: in_valid / in_stall / in_data (hue in 1/64 degree,
//   saturation and brightness as 8-bit fractions). A transaction happens on
//   a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall / out_data (red, green, blue).
//   A transaction happens on a rising edge with out_valid high and out_stall
//   low; a stalled result holds on out_data until taken.
//   Throughput: one pixel per clock cycle, sustained while the receiver does not stall.
//   Depth: six register stages between input and output. The depth is
//   set by the two rounds of multiply and divide-by-255 rounding.
//   Stall: each stage accepts when it is empty or its successor accepts, so
//   bubbles are squeezed out and in_stall rises only once all six stages
//   hold pixels and the receiver stalls.
//   Reset (rst_n low, synchronous): drop all in-flight pixels; valid bits
//   clear, payload registers keep whatever they had.
//   Hue of 23040 or more selects the last sector's mapping.
module hsv_to_rgb_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hsv2rgb_pkg::hsv_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hsv2rgb_pkg::rgb_t  out_data
);
  import hsv2rgb_pkg::*;

  logic  in_ready;
  logic  frac_valid, frac_ready;
  frac_t frac_data;
  logic  prod_valid, prod_ready;
  prod_t prod_data;

  // Sector, remainder and fraction f; also brightness * (1 - s).
  hsv2rgb_frac u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (frac_valid),
    .out_ready (frac_ready),
    .out_data  (frac_data)
  );

  // Round p; form the q and t products.
  hsv2rgb_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frac_valid),
    .in_ready  (frac_ready),
    .in_data   (frac_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  // Round q and t, map by sector, hold in the output register.
  hsv2rgb_sel u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !in_ready;

endmodule

### rtl/hsv2rgb_frac.sv
// Sector split and fraction stages (two register stages).
module hsv2rgb_frac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsv2rgb_pkg::hsv_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsv2rgb_pkg::frac_t  out_data
);
  import hsv2rgb_pkg::*;

  logic                 s1_v_r;
  logic [SecBits-1:0]   s1_sec_r, s1_sec_nxt;
  logic [RemmBits-1:0]  s1_remm_r, s1_remm_nxt;
  logic [ColorBits-1:0] s1_sat_r, s1_bri_r;
  logic                 s1_rdy;

  logic                 s2_v_r;
  frac_t                s2_r, s2_nxt;
  logic                 s2_rdy;

  logic [HueHiBits-1:0]  hue_hi;
  logic [SecMulBits-1:0] sec_mul;
  logic [HueHiBits:0]    sec15;
  logic [HueHiBits-1:0]  rem_hi;
  logic [RemBits-1:0]    rem;
  logic [DivInBits-1:0]  div_in;
  logic [FMulBits-1:0]   f_mul;

  assign s2_rdy   = !s2_v_r || out_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // Stage 1: sector = hue / 3840, then rem * MaxV by shift and subtract.
  always_comb begin
    hue_hi     = in_data.hue[HueBits-1:SpanShift];
    sec_mul    = SecMulBits'(hue_hi) * SecMulBits'(HueSecMul);
    s1_sec_nxt = sec_mul[HueSecShift +: SecBits];
    sec15      = {s1_sec_nxt, 4'b0000} - (HueHiBits + 1)'(s1_sec_nxt);
    rem_hi     = hue_hi - sec15[HueHiBits-1:0];
    rem        = {rem_hi[RemHiBits-1:0], in_data.hue[SpanShift-1:0]};
    s1_remm_nxt = {rem, {ColorBits{1'b0}}} - RemmBits'(rem);
  end

  // Stage 2: f = (rem * MaxV) / 3840 by reciprocal, and p's product.
  always_comb begin
    div_in        = s1_remm_r[RemmBits-1:SpanShift];
    f_mul         = FMulBits'(div_in) * FMulBits'(Recip15);
    s2_nxt.sector = s1_sec_r;
    s2_nxt.sat    = s1_sat_r;
    s2_nxt.bri    = s1_bri_r;
    s2_nxt.f      = f_mul[RecipShift +: ColorBits];
    s2_nxt.pv     = ProdBits'(s1_bri_r) * ProdBits'(MaxV - s1_sat_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_sec_r  <= s1_sec_nxt;
      s1_remm_r <= s1_remm_nxt;
      s1_sat_r  <= in_data.saturation;
      s1_bri_r  <= in_data.brightness;
    end
    if (s2_rdy && s1_v_r) s2_r <= s2_nxt;
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

endmodule

### rtl/hsv2rgb_prod.sv
// Product stages for q and t (three register stages).
module hsv2rgb_prod (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsv2rgb_pkg::frac_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsv2rgb_pkg::prod_t  out_data
);
  import hsv2rgb_pkg::*;

  typedef struct packed {
    logic [SecBits-1:0]   sector;
    logic [ColorBits-1:0] bri;
    logic [ColorBits-1:0] p;
    logic [ProdBits-1:0]  sf;
    logic [ProdBits-1:0]  sfc;
  } mul_t;

  typedef struct packed {
    logic [SecBits-1:0]   sector;
    logic [ColorBits-1:0] bri;
    logic [ColorBits-1:0] p;
    logic [ColorBits-1:0] qm;
    logic [ColorBits-1:0] tm;
  } cmp_t;

  logic  s3_v_r, s4_v_r, s5_v_r;
  logic  s3_rdy, s4_rdy, s5_rdy;
  mul_t  s3_r, s3_nxt;
  cmp_t  s4_r, s4_nxt;
  prod_t s5_r, s5_nxt;

  assign s5_rdy   = !s5_v_r || out_ready;
  assign s4_rdy   = !s4_v_r || s5_rdy;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign in_ready = s3_rdy;

  // Stage 3: s*f and s*(1-f); round p.
  always_comb begin
    s3_nxt.sector = in_data.sector;
    s3_nxt.bri    = in_data.bri;
    s3_nxt.p      = rnd_div(in_data.pv);
    s3_nxt.sf     = ProdBits'(in_data.sat) * ProdBits'(in_data.f);
    s3_nxt.sfc    = ProdBits'(in_data.sat) * ProdBits'(MaxV - in_data.f);
  end

  // Stage 4: round and complement.
  always_comb begin
    s4_nxt.sector = s3_r.sector;
    s4_nxt.bri    = s3_r.bri;
    s4_nxt.p      = s3_r.p;
    s4_nxt.qm     = MaxV - rnd_div(s3_r.sf);
    s4_nxt.tm     = MaxV - rnd_div(s3_r.sfc);
  end

  // Stage 5: scale by brightness.
  always_comb begin
    s5_nxt.sector = s4_r.sector;
    s5_nxt.bri    = s4_r.bri;
    s5_nxt.p      = s4_r.p;
    s5_nxt.qv     = ProdBits'(s4_r.bri) * ProdBits'(s4_r.qm);
    s5_nxt.tv     = ProdBits'(s4_r.bri) * ProdBits'(s4_r.tm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (s3_rdy) s3_v_r <= in_valid;
      if (s4_rdy) s4_v_r <= s3_v_r;
      if (s5_rdy) s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && in_valid) s3_r <= s3_nxt;
    if (s4_rdy && s3_v_r)   s4_r <= s4_nxt;
    if (s5_rdy && s4_v_r)   s5_r <= s5_nxt;
  end

  assign out_valid = s5_v_r;
  assign out_data  = s5_r;

endmodule

### rtl/hsv2rgb_sel.sv
// Final rounding, sector select and output register.
module hsv2rgb_sel (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsv2rgb_pkg::prod_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hsv2rgb_pkg::rgb_t   out_data
);
  import hsv2rgb_pkg::*;

  logic                 out_valid_r;
  rgb_t                 out_data_r, out_data_nxt;
  logic [ColorBits-1:0] q, t, v, p;

  assign in_ready = !out_valid_r || !out_stall;

  always_comb begin
    v = in_data.bri;
    p = in_data.p;
    q = rnd_div(in_data.qv);
    t = rnd_div(in_data.tv);
    case (in_data.sector)
      SecRedGrn: out_data_nxt = '{red: v, green: t, blue: p};
      SecGrnRed: out_data_nxt = '{red: q, green: v, blue: p};
      SecGrnBlu: out_data_nxt = '{red: p, green: v, blue: t};
      SecBluGrn: out_data_nxt = '{red: p, green: q, blue: v};
      SecBluRed: out_data_nxt = '{red: t, green: p, blue: v};
      default:   out_data_nxt = '{red: v, green: p, blue: q};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/hsv2rgb_chk.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
module hsv2rgb_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input hsv2rgb_pkg::hsv_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input hsv2rgb_pkg::rgb_t  out_data
);
  import hsv2rgb_pkg::*;

  localparam logic [2:0] Depth = 3'd6;

  logic       in_acc, out_acc;
  logic [2:0] cnt_r, cnt_nxt;
  logic [HueBits-1:0] hue_seen;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign hue_seen = in_data.hue;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) cnt_nxt = cnt_r + 3'd1;
    if (!in_acc && out_acc) cnt_nxt = cnt_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A result needs a transaction in flight.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("result without an accepted pixel");

  // Never more pixels in flight than pipeline stages.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Depth)
    else $error("too many pixels in flight");

  // An empty output register never backs up the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with output empty");

  // Known-value check on the input hue, tying the port into the checker.
  a_hue_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(hue_seen))
    else $error("unknown hue on a valid input");

endmodule

bind hsv_to_rgb_converter hsv2rgb_chk u_chk (.*);

### verif/hsv_to_rgb_converter_test.sv
// Self-checking testbench for the pipelined HSV to RGB pixel converter.
module hsv_to_rgb_converter_test;
  import hsv2rgb_pkg::*;

  // Sector span in hue units, and run sizing.
  localparam int HueSpan       = 3840;
  localparam int RandomPixels  = 1050;
  localparam int DrainCycles   = 16;
  localparam int CycleLimit    = 200000;

  // Predicts each RGB result and matches the converter output against it in order.
  class rgb_scoreboard;
    rgb_t pending_rgb[$];
    int   mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Round to nearest after dividing by full scale.
    function automatic logic [ColorBits-1:0] scale_down(input int x);
      return ColorBits'((x + int'(HalfV)) / int'(MaxV));
    endfunction

    // Convert one HSV pixel to the RGB pixel the block must produce.
    function automatic rgb_t convert_pixel(input hsv_t px);
      int   hue_val;
      int   rem;
      int   full;
      logic [SecBits-1:0]   sector;
      logic [ColorBits-1:0] s, v, f, p, q, t;
      rgb_t res;
      full    = int'(MaxV);
      hue_val = int'(px.hue);
      s       = px.saturation;
      v       = px.brightness;
      if (s == '0) begin
        res.red   = v;
        res.green = v;
        res.blue  = v;
        return res;
      end
      sector = SecBits'(hue_val / HueSpan);
      rem    = hue_val % HueSpan;
      f      = ColorBits'((rem * full) / HueSpan);
      p      = scale_down(int'(v) * (full - int'(s)));
      q      = scale_down(int'(v) * (full - int'(scale_down(int'(s) * int'(f)))));
      t      = scale_down(int'(v) * (full - int'(scale_down(int'(s) * (full - int'(f))))));
      case (sector)
        SecRedGrn: begin res.red = v; res.green = t; res.blue = p; end
        SecGrnRed: begin res.red = q; res.green = v; res.blue = p; end
        SecGrnBlu: begin res.red = p; res.green = v; res.blue = t; end
        SecBluGrn: begin res.red = p; res.green = q; res.blue = v; end
        SecBluRed: begin res.red = t; res.green = p; res.blue = v; end
        default:   begin res.red = v; res.green = p; res.blue = q; end
      endcase
      return res;
    endfunction

    function void note_pixel(input hsv_t px);
      pending_rgb.push_back(convert_pixel(px));
    endfunction

    function void check_rgb(input rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        mismatch_count++;
        return;
      end
      want = pending_rgb.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red mismatch expected %0d actual %0d", $time, want.red, got.red);
        mismatch_count++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green mismatch expected %0d actual %0d",
                 $time, want.green, got.green);
        mismatch_count++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue mismatch expected %0d actual %0d", $time, want.blue, got.blue);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return pending_rgb.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  hsv_t in_data;
  logic out_valid;
  logic out_stall;
  rgb_t out_data;

  rgb_scoreboard sb = new();

  // Receiver pacing: cycles of stall still owed before the next result.
  int  hold_left  = 0;
  int  taken      = 0;
  int  taken_seen = 0;
  bit  recv_burst = 0;
  int  cycle_count = 0;

  hsv_to_rgb_converter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10-unit clock, starting low.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if the pipeline hangs or results never drain.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** hsv_to_rgb_converter: FAILED **");
      $finish;
    end
  end

  // Output monitor: a transaction completes on a rising edge with valid high and
  // stall low. Check it and count it.
  // Every so often flip into a burst stretch where the receiver never stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_rgb(out_data);
      taken++;
      if (taken % 80 == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // Drive stall at the falling edge, one assignment per step. After each
  // taken result, draw how long to stall before taking the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (taken != taken_seen) begin
        taken_seen = taken;
        hold_left  = recv_burst ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one pixel after an idle gap. Called at a falling edge; returns at the
  // falling edge after the transaction. Keep in_valid high across back-to-back
  // pixels so it is never lowered and raised in the same step.
  task automatic send_pixel(input hsv_t px, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  function automatic hsv_t make_pixel(input int h, input int s, input int v);
    hsv_t px;
    px.hue        = HueBits'(h);
    px.saturation = ColorBits'(s);
    px.brightness = ColorBits'(v);
    return px;
  endfunction

  // Random pixel: mostly in-range hues, some past the last sector, some hugging
  // sector boundaries; saturation and brightness lean on their extremes at times.
  function automatic hsv_t random_pixel();
    int h, s, v, pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)      h = $urandom_range(0, 6 * HueSpan - 1);
    else if (pick < 92) h = $urandom_range(6 * HueSpan, (1 << HueBits) - 1);
    else                h = $urandom_range(0, 8) * HueSpan + $urandom_range(0, 2) - 1;
    if (h < 0) h = 0;
    pick = $urandom_range(0, 9);
    if (pick == 0)      s = 0;
    else if (pick == 1) s = int'(MaxV);
    else                s = $urandom_range(0, int'(MaxV));
    pick = $urandom_range(0, 9);
    if (pick == 0)      v = 0;
    else if (pick == 1) v = int'(MaxV);
    else                v = $urandom_range(0, int'(MaxV));
    return make_pixel(h, s, v);
  endfunction

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 3);
  endfunction

  initial begin
    hsv_t directed[$];
    bit   send_burst;
    int   m;

    in_valid  = 1'b0;
    in_data   = '0;
    rst_n     = 1'b0;
    send_burst = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every sector edge, hues past the last sector, grey, and the
    // extremes of saturation and brightness.
    directed.push_back(make_pixel(0, 255, 255));
    directed.push_back(make_pixel(HueSpan - 1, 255, 255));
    for (m = 1; m <= 6; m++) directed.push_back(make_pixel(m * HueSpan, 255, 255));
    directed.push_back(make_pixel(6 * HueSpan - 1, 255, 255));
    directed.push_back(make_pixel(7 * HueSpan, 200, 100));
    directed.push_back(make_pixel((1 << HueBits) - 1, 255, 255));
    directed.push_back(make_pixel(0, 0, 255));
    directed.push_back(make_pixel(12345, 0, 0));
    directed.push_back(make_pixel((1 << HueBits) - 1, 0, 128));
    directed.push_back(make_pixel(5000, 1, 255));
    directed.push_back(make_pixel(5000, 255, 0));
    directed.push_back(make_pixel(20000, 255, 1));
    directed.push_back(make_pixel(HueSpan / 2, 128, 128));
    directed.push_back(make_pixel(2 * HueSpan + HueSpan / 2, 254, 254));
    directed.push_back(make_pixel(16384, 170, 85));
    directed.push_back(make_pixel(100, 85, 170));
    directed.push_back(make_pixel(3 * HueSpan + 1, 1, 1));
    foreach (directed[k]) send_pixel(directed[k], draw_gap(1'b0));

    // Random stream; switch into gapless stretches now and then.
    for (m = 0; m < RandomPixels; m++) begin
      if (m % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_pixel(random_pixel(), draw_gap(send_burst));
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then wait out the DrainCycles margin
    // to catch anything extra.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.mismatch_count == 0) begin
      $display("** hsv_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter: FAILED **");
    end
    $finish;
  end

endmodule

### hsv_to_rgb_converter.f
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_frac.sv
rtl/hsv2rgb_prod.sv
rtl/hsv2rgb_sel.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsv2rgb_chk.sv
verif/hsv_to_rgb_converter_test.sv
